FILE: sv/lcr_pkg.sv
package lcr_pkg;

  // widths fixed by the converter interface and the result fields
  localparam int RAW_W   = 24;
  localparam int PULSE_W = 5;
  localparam int DIV_W   = 16;

  // data pulses counted against the gain select setting
  localparam logic [PULSE_W-1:0] GAIN_BASE     = 5'd24;
  localparam logic [PULSE_W-1:0] GAIN_MAX      = 5'd27;
  localparam logic [PULSE_W-1:0] PULSES_RESET  = 5'd25;
  localparam logic [DIV_W-1:0]   DIVISOR_RESET = 16'd410;

  // register indexes on the configuration port
  localparam logic REG_TOTAL_PULSES  = 1'b0;
  localparam logic REG_SCALE_DIVISOR = 1'b1;

  // serial clock phase of the front end
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // what the back end does to the running weight
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ZERO,
    OP_DIVIDE
  } weight_op_t;

  // back end state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // one classified tick on its way to the back end
  typedef struct packed {
    logic             clock_pin;
    logic             sample_valid;
    logic [RAW_W-1:0] raw;
    logic             tare_stored;
    weight_op_t       op;
    logic [RAW_W-1:0] numer;
  } job_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/lcr_if.sv
// input tick channel
interface lcr_in_if;
  logic valid;
  logic ready;
  logic data_pin;
  logic tare_request;

  modport source (output valid, output data_pin, output tare_request, input ready);
  modport sink (input valid, input data_pin, input tare_request, output ready);
endinterface

// result channel
interface lcr_out_if;
  logic        valid;
  logic        ready;
  logic        clock_pin;
  logic        sample_valid;
  logic [23:0] raw_sample;
  logic [23:0] weight;
  logic        tare_stored;

  modport source (output valid, output clock_pin, output sample_valid, output raw_sample,
                  output weight, output tare_stored, input ready);
  modport sink (input valid, input clock_pin, input sample_valid, input raw_sample,
                input weight, input tare_stored, output ready);
endinterface

FILE: sv/lcr_front.sv
module lcr_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  lcr_in_if.sink            in_ch,
  input  logic [4:0]        total_pulses,
  input  lcr_pkg::q_status_t q_stat,
  output logic              push,
  output lcr_pkg::job_t     job
);
  import lcr_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] TOP_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  phase_t                  phase, phase_next;
  logic [PULSE_W-1:0]      pulse_count, pulse_count_next;
  logic [SAMPLE_BITS-1:0]  shift, shift_next;
  logic [SAMPLE_BITS-1:0]  tare_count, tare_count_next;
  logic                    tare_pending, tare_pending_next;

  logic                    accept;
  logic [PULSE_W-1:0]      extra;
  logic [PULSE_W-1:0]      needed;
  logic [PULSE_W-1:0]      count_inc;
  logic                    done;
  logic                    tare_eff;
  logic [SAMPLE_BITS-1:0]  shift_in;
  logic [SAMPLE_BITS-1:0]  raw;

  // handshake towards the queue
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept;

  // gain select pulses clamped to one..three
  always_comb begin
    if (total_pulses <= GAIN_BASE) begin
      extra = 5'd1;
    end else if (total_pulses >= GAIN_MAX) begin
      extra = 5'd3;
    end else begin
      extra = total_pulses - GAIN_BASE;
    end
  end

  assign needed    = PULSE_W'(SAMPLE_BITS) + extra;
  assign count_inc = pulse_count + 5'd1;
  assign done      = (phase == PH_LOW) && (count_inc >= needed);
  assign tare_eff  = tare_pending || in_ch.tare_request;
  assign shift_in  = (pulse_count < PULSE_W'(SAMPLE_BITS)) ?
                     {shift[SAMPLE_BITS-2:0], in_ch.data_pin} : shift;
  assign raw       = shift_in ^ TOP_BIT;

  // next phase
  always_comb begin
    unique case (phase)
      PH_IDLE: phase_next = in_ch.data_pin ? PH_IDLE : PH_HIGH;
      PH_HIGH: phase_next = PH_LOW;
      PH_LOW:  phase_next = done ? PH_IDLE : PH_HIGH;
      default: phase_next = PH_IDLE;
    endcase
  end

  // classify the tick and update the sample state
  always_comb begin
    job               = '0;
    job.op            = OP_HOLD;
    pulse_count_next  = '0;
    shift_next        = '0;
    tare_count_next   = tare_count;
    tare_pending_next = tare_eff;
    unique case (phase)
      PH_HIGH: begin
        job.clock_pin    = 1'b1;
        pulse_count_next = pulse_count;
        shift_next       = shift;
      end
      PH_LOW: begin
        pulse_count_next = count_inc;
        shift_next       = shift_in;
        if (done) begin
          job.sample_valid = 1'b1;
          job.raw          = RAW_W'(raw);
          pulse_count_next = '0;
          shift_next       = '0;
          if (tare_eff) begin
            tare_count_next   = raw;
            tare_pending_next = 1'b0;
            job.tare_stored   = 1'b1;
          end else if (raw > tare_count) begin
            job.op    = OP_DIVIDE;
            job.numer = RAW_W'(raw - tare_count);
          end else if (raw != '0) begin
            job.op = OP_ZERO;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pulse_count  <= '0;
      shift        <= '0;
      tare_count   <= '0;
      tare_pending <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      pulse_count  <= pulse_count_next;
      shift        <= shift_next;
      tare_count   <= tare_count_next;
      tare_pending <= tare_pending_next;
    end
  end

endmodule

FILE: sv/lcr_queue.sv
module lcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcr_pkg::job_t      push_data,
  input  logic               pop,
  output lcr_pkg::job_t      head,
  output lcr_pkg::q_status_t stat
);
  import lcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/lcr_back.sv
module lcr_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  lcr_pkg::job_t      head,
  input  lcr_pkg::q_status_t q_stat,
  output logic               pop,
  input  logic [15:0]        divisor,
  lcr_out_if.source          out_ch
);
  import lcr_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  bk_state_t               state, state_next;
  logic                    out_valid;
  job_t                    out_job;
  logic [SAMPLE_BITS-1:0]  out_weight;
  logic [SAMPLE_BITS-1:0]  cur_weight;

  job_t                    pend_job;
  logic [DIV_W-1:0]        rem;
  logic [SAMPLE_BITS-1:0]  quo;
  logic [CNT_W-1:0]        cnt;

  logic                    out_free;
  logic                    last;
  logic [DIV_W:0]          trial;
  logic                    ge;
  logic [DIV_W-1:0]        rem_next;
  logic                    start_div;
  logic                    load_out;
  job_t                    new_job;
  logic [SAMPLE_BITS-1:0]  new_weight;

  assign out_free = !out_valid || out_ch.ready;
  assign last     = (cnt == CNT_W'(SAMPLE_BITS - 1));

  // one restoring division step per cycle
  assign trial    = {rem, quo[SAMPLE_BITS-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign rem_next = ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty && out_free && head.op == OP_DIVIDE) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // queue pop, divider start and result load
  always_comb begin
    pop        = 1'b0;
    start_div  = 1'b0;
    load_out   = 1'b0;
    new_job    = head;
    new_weight = cur_weight;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop = 1'b1;
          if (head.op == OP_DIVIDE) begin
            start_div = 1'b1;
          end else begin
            load_out = 1'b1;
            if (head.op == OP_ZERO) begin
              new_weight = '0;
            end
          end
        end
      end
      BK_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          new_job    = pend_job;
          new_weight = quo;
        end
      end
      default: begin
      end
    endcase
  end

  // control and running weight
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      out_valid  <= 1'b0;
      cur_weight <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid  <= 1'b1;
        cur_weight <= new_weight;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register and divider datapath
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_job    <= new_job;
      out_weight <= new_weight;
    end
    if (start_div) begin
      pend_job <= head;
      rem      <= '0;
      quo      <= head.numer[SAMPLE_BITS-1:0];
      cnt      <= '0;
    end else if (state == BK_DIV) begin
      rem <= rem_next;
      quo <= {quo[SAMPLE_BITS-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.clock_pin    = out_job.clock_pin;
  assign out_ch.sample_valid = out_job.sample_valid;
  assign out_ch.raw_sample   = out_job.raw;
  assign out_ch.weight       = RAW_W'(out_weight);
  assign out_ch.tare_stored  = out_job.tare_stored;

endmodule

FILE: sv/load_cell_adc_serial_reader_core.sv
// Two-wire load cell converter readout with tare. Each input transfer is one half period of
// the serial clock and gives exactly one result transfer carrying the clock level to drive,
// plus the finished sample, tare flag and net weight on the tick that ends a conversion.
// A tick whose sample is divided into a new net weight passes the back end's restoring
// divider (one quotient bit per cycle); every other tick goes straight to the result
// register. The front end keeps taking ticks into a QUEUE_DEPTH entry queue meanwhile and
// stalls its input once that queue is full; the back end takes no new tick from the queue
// until the division has finished and its result has been loaded.
// Registers: 0x0 total_pulses (25..27, clamped), 0x4 scale_divisor (0 acts as 1).
module load_cell_adc_serial_reader_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  lcr_in_if.sink      in_ch,
  lcr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcr_pkg::*;

  logic [PULSE_W-1:0] total_pulses;
  logic [DIV_W-1:0]   scale_divisor;
  logic [DIV_W-1:0]   div_eff;
  logic               cfg_write;

  logic               push;
  logic               pop;
  job_t               push_job;
  job_t               head_job;
  q_status_t          q_stat;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pulses  <= PULSES_RESET;
      scale_divisor <= DIVISOR_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_TOTAL_PULSES:  total_pulses  <= pwdata[PULSE_W-1:0];
        REG_SCALE_DIVISOR: scale_divisor <= pwdata[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_PULSES:  prdata = 32'(total_pulses);
      REG_SCALE_DIVISOR: prdata = 32'(scale_divisor);
      default:           prdata = '0;
    endcase
  end

  // zero divisor behaves as one
  assign div_eff = (scale_divisor == '0) ? 16'd1 : scale_divisor;

  // serial front end
  lcr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .total_pulses (total_pulses),
    .q_stat       (q_stat),
    .push         (push),
    .job          (push_job)
  );

  // decoupling queue
  lcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .stat      (q_stat)
  );

  // weight back end
  lcr_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head_job),
    .q_stat  (q_stat),
    .pop     (pop),
    .divisor (div_eff),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  // tare capture only on a finished conversion
  a_tare_on_sample: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.tare_stored || out_ch.sample_valid))
    else $error("tare flag without a finished sample");

  // raw sample field is zero on plain ticks
  a_raw_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.sample_valid) |-> (out_ch.raw_sample == '0))
    else $error("raw sample on a tick without conversion");

  // queue status is never full and empty together
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // nothing pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: bench/load_cell_adc_serial_reader_core_tb.sv
module load_cell_adc_serial_reader_core_tb;
  import lcr_pkg::*;

  localparam logic [RAW_W-1:0] SIGN_FLIP = {1'b1, {(RAW_W-1){1'b0}}};
  localparam int TARGET_TICKS = 1950;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_WAIT  = RAW_W + 16;

  // one result transfer, in port order
  typedef struct packed {
    logic             clock_pin;
    logic             sample_valid;
    logic [RAW_W-1:0] raw_sample;
    logic [RAW_W-1:0] weight;
    logic             tare_stored;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcr_in_if  in_ch ();
  lcr_out_if out_ch ();

  load_cell_adc_serial_reader_core dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // readout state as the bench sees it
  phase_t             rd_phase     = PH_IDLE;
  logic [PULSE_W-1:0] rd_pulses    = '0;
  logic               rd_clock     = 1'b0;
  logic [RAW_W-1:0]   rd_shift     = '0;
  logic [RAW_W-1:0]   rd_tare      = '0;
  logic [RAW_W-1:0]   rd_weight    = '0;
  logic               rd_tare_pend = 1'b0;
  logic [PULSE_W-1:0] reg_pulses   = PULSES_RESET;
  logic [DIV_W-1:0]   reg_divisor  = DIVISOR_RESET;

  tick_result_t predicted_outputs[$];
  int           mismatches = 0;
  int           ticks_sent = 0;
  int           burst_left = 0;
  logic         hold_req   = 1'b0;

  // data pulses plus clamped gain select pulses
  function automatic int pulses_per_conversion(input logic [PULSE_W-1:0] setting);
    if (setting <= GAIN_BASE) return GAIN_BASE + 1;
    if (setting >= GAIN_MAX) return GAIN_MAX;
    return setting;
  endfunction

  // advance the readout by one half clock period
  task automatic predict_tick(input logic data, input logic tare, output tick_result_t res);
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] div;
    res = '0;
    if (tare) rd_tare_pend = 1'b1;
    case (rd_phase)
      PH_HIGH: begin
        rd_clock = 1'b1;
        rd_phase = PH_LOW;
      end
      PH_LOW: begin
        rd_clock = 1'b0;
        if (rd_pulses < RAW_W) rd_shift = {rd_shift[RAW_W-2:0], data};
        rd_pulses = rd_pulses + 1'b1;
        if (rd_pulses >= pulses_per_conversion(reg_pulses)) begin
          raw = rd_shift ^ SIGN_FLIP;
          res.sample_valid = 1'b1;
          res.raw_sample = raw;
          if (rd_tare_pend) begin
            rd_tare = raw;
            rd_tare_pend = 1'b0;
            res.tare_stored = 1'b1;
          end else if (raw > rd_tare) begin
            div = (reg_divisor == '0) ? RAW_W'(1) : RAW_W'(reg_divisor);
            rd_weight = (raw - rd_tare) / div;
          end else if (raw != '0) begin
            rd_weight = '0;
          end
          rd_phase = PH_IDLE;
          rd_pulses = '0;
          rd_shift = '0;
        end else begin
          rd_phase = PH_HIGH;
        end
      end
      default: begin
        rd_clock = 1'b0;
        rd_phase = data ? PH_IDLE : PH_HIGH;
        rd_pulses = '0;
        rd_shift = '0;
      end
    endcase
    res.clock_pin = rd_clock;
    res.weight = rd_weight;
  endtask

  // prediction on input transfers, checking on result transfers
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SCALE_DIVISOR) reg_divisor = pwdata[DIV_W-1:0];
        else reg_pulses = pwdata[PULSE_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_tick(in_ch.data_pin, in_ch.tare_request, want);
        predicted_outputs.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.clock_pin, out_ch.sample_valid, out_ch.raw_sample, out_ch.weight,
               out_ch.tare_stored};
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: clk %b valid %b raw %h weight %h tare %b",
                     got.clock_pin, got.sample_valid, got.raw_sample, got.weight,
                     got.tare_stored);
        end else begin
          want = predicted_outputs.pop_front();
          if (got.clock_pin !== want.clock_pin || got.sample_valid !== want.sample_valid ||
              got.raw_sample !== want.raw_sample || got.weight !== want.weight ||
              got.tare_stored !== want.tare_stored) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected clk %b valid %b raw %h weight %h tare %b, %s",
                       want.clock_pin, want.sample_valid, want.raw_sample, want.weight,
                       want.tare_stored,
                       $sformatf("got clk %b valid %b raw %h weight %h tare %b",
                                 got.clock_pin, got.sample_valid, got.raw_sample,
                                 got.weight, got.tare_stored));
          end
        end
      end
    end
  end

  // result side stalls, with a long hold-off on request
  initial begin
    int mode;
    int left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = (left % 4 == 0);
        default: out_ch.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // stall watchdog
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        stalled = 0;
      else
        stalled++;
    end
    $display("load_cell_adc_serial_reader_core test failed");
    $finish;
  end

  // one tick transfer, in bursts with random gaps between them
  task automatic send_tick(input logic data, input logic tare);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      burst_left--;
    end
    in_ch.valid = 1'b1;
    in_ch.data_pin = data;
    in_ch.tare_request = tare;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (predicted_outputs.size() != 0) @(negedge clk);
  endtask

  // clock out any conversion in progress with the pin high
  task automatic settle_idle();
    while (rd_phase != PH_IDLE) send_tick(1'b1, 1'b0);
  endtask

  task automatic program_register(input logic idx, input logic [31:0] value);
    settle_idle();
    drain_results();
    repeat (4) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // full conversion yielding the given sample; tare raised on tick tare_at (-1 for none)
  task automatic send_conversion(input logic [RAW_W-1:0] raw, input int tare_at);
    logic [RAW_W-1:0] bits;
    int n;
    int t;
    settle_idle();
    bits = raw ^ SIGN_FLIP;
    n = pulses_per_conversion(reg_pulses);
    repeat ($urandom_range(0, 2)) send_tick(1'b1, 1'b0);
    send_tick(1'b0, tare_at == 0);
    for (int k = 0; k < n; k++) begin
      t = 2 * k + 1;
      // pin level on the high tick is never sampled
      send_tick(1'($urandom_range(0, 1)), tare_at == t);
      send_tick((k < RAW_W) ? bits[RAW_W-1-k] : 1'($urandom_range(0, 1)), tare_at == t + 1);
    end
  endtask

  function automatic logic [RAW_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return rd_tare;
      3: return rd_tare - RAW_W'($urandom_range(1, 64));
      4: return rd_tare + RAW_W'($urandom_range(1, 64));
      5: return SIGN_FLIP;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  function automatic int pick_tare_tick();
    if ($urandom_range(0, 7) != 0) return -1;
    return $urandom_range(0, 2 * pulses_per_conversion(reg_pulses));
  endfunction

  // reset settings: full scale, held zero sample, tare paths
  task automatic test_directed();
    int last;
    last = 2 * pulses_per_conversion(reg_pulses);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_conversion('1, -1);
    send_conversion('0, -1);
    send_conversion(24'h001000, last);
    send_conversion(24'h000800, -1);
    send_conversion('1, -1);
    send_conversion(24'h001000, -1);
    send_conversion('1, -1);
    send_conversion('0, -1);
    send_conversion(SIGN_FLIP, -1);
    // tare requested while idle stays pending
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_conversion(24'h123456, -1);
    send_conversion(24'h123457, -1);
    send_conversion(24'h7FFFFF, 5);
  endtask

  // pulse counts including the clamped ones, divisor extremes including zero
  task automatic test_register_extremes();
    logic [PULSE_W-1:0] pulse_set[7] = '{5'd25, 5'd26, 5'd27, 5'd0, 5'd24, 5'd31, 5'd28};
    logic [DIV_W-1:0]   div_set[7]   = '{16'd1, 16'd65535, 16'd0, 16'd410, 16'd2, 16'd7,
                                         16'h8000};
    for (int i = 0; i < 7; i++) begin
      program_register(REG_TOTAL_PULSES, ($urandom() & ~32'h1F) | pulse_set[i]);
      program_register(REG_SCALE_DIVISOR, ($urandom() & ~32'hFFFF) | div_set[i]);
      send_conversion('1, -1);
      send_conversion(pick_sample(), pick_tare_tick());
    end
  endtask

  // receiver holds off while ticks keep coming, then the sender waits for all results
  task automatic test_backpressure();
    program_register(REG_SCALE_DIVISOR, 32'd3);
    hold_req = 1'b1;
    repeat (3) send_conversion(pick_sample(), pick_tare_tick());
    drain_results();
    send_conversion(pick_sample(), -1);
  endtask

  // random settings, conversions with random content, and stray pin activity
  task automatic test_random();
    while (ticks_sent < TARGET_TICKS) begin
      if ($urandom_range(0, 3) == 0)
        program_register(REG_TOTAL_PULSES,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(25, 27));
      if ($urandom_range(0, 3) == 0)
        program_register(REG_SCALE_DIVISOR,
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(1, 600));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(10, 40))
            send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
        else
          send_conversion(pick_sample(), pick_tare_tick());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_pin = 1'b1;
    in_ch.tare_request = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();

    settle_idle();
    drain_results();
    repeat (SETTLE_WAIT) @(negedge clk);
    mismatches += predicted_outputs.size();
    if (mismatches == 0) begin
      $display("load_cell_adc_serial_reader_core test passed");
    end else begin
      $display("load_cell_adc_serial_reader_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lcr_pkg.sv
sv/lcr_if.sv
sv/lcr_front.sv
sv/lcr_queue.sv
sv/lcr_back.sv
sv/load_cell_adc_serial_reader_core.sv
bench/load_cell_adc_serial_reader_core_tb.sv
